[src/tecs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tecs_pkg: shared types and constants
// opcodes, register indexes, action and fault codes and sequencer states
// ----------------------------------------------------------------------------
package tecs_pkg;

    localparam int RegCount = 12;

    typedef logic [3:0] t_reg_idx;
    localparam t_reg_idx REG_S  = 4'd8;
    localparam t_reg_idx REG_T  = 4'd9;
    localparam t_reg_idx REG_P0 = 4'd10;
    localparam t_reg_idx REG_P1 = 4'd11;

    typedef enum logic [1:0] {
        ACT_STEP  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        FLT_NONE   = 2'd0,
        FLT_OPCODE = 2'd1,
        FLT_DIV0   = 2'd2,
        FLT_REG    = 2'd3
    } t_fault;

    localparam logic [7:0] OP_LDT  = 8'h00;
    localparam logic [7:0] OP_MOV  = 8'h01;
    localparam logic [7:0] OP_ADD  = 8'h02;
    localparam logic [7:0] OP_SUB  = 8'h03;
    localparam logic [7:0] OP_MUL  = 8'h04;
    localparam logic [7:0] OP_DIV  = 8'h05;
    localparam logic [7:0] OP_MOD  = 8'h06;
    localparam logic [7:0] OP_AND  = 8'h07;
    localparam logic [7:0] OP_OR   = 8'h08;
    localparam logic [7:0] OP_XOR  = 8'h09;
    localparam logic [7:0] OP_NOT  = 8'h0A;
    localparam logic [7:0] OP_SHL  = 8'h0B;
    localparam logic [7:0] OP_SHR  = 8'h0C;
    localparam logic [7:0] OP_EQ   = 8'h0D;
    localparam logic [7:0] OP_GT   = 8'h0E;
    localparam logic [7:0] OP_JMP  = 8'h0F;
    localparam logic [7:0] OP_LD   = 8'h10;
    localparam logic [7:0] OP_ST   = 8'h11;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOST,
        ST_FETCH_OP,
        ST_FETCH_ARG,
        ST_ARG,
        ST_DECODE,
        ST_DIV,
        ST_MEM,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage

[src/tiny_eight_bit_cpu_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_eight_bit_cpu_step: small 8-bit processor, one action per transfer
// twelve byte registers, 64 KiB single-port memory, shared divider
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the 64 KiB memory, one byte
// per cycle (65536 writes, then it leaves the clearing state), and takes no
// transfer until it ends. Then each input transfer is one action. A host
// read, host write or the unused action passes through the host access and
// result states; a step passes through opcode fetch, argument fetch,
// argument capture, decode, write back and result; a load or store through T
// adds a data access before write back, and divide or modulo run through a
// restoring divider, one quotient bit per cycle for all eight bits. A step
// that faults skips from decode to the result. The single memory port sets
// the separate fetches, and read data is registered, landing in the cycle
// after its address. One action is handled at a time; the result sits in an
// output register until taken, and output stall holds off the next accept.
module tiny_eight_bit_cpu_step
    import tecs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_host_address,
    input  logic [7:0]  i_host_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic [7:0]  o_executed_opcode,
    output logic [7:0]  o_executed_argument,
    output logic [1:0]  o_fault
);

    t_state      r_state, n_state;
    logic [7:0]  r_mem [0:65535];
    logic [7:0]  r_rf  [0:RegCount-1];
    logic [7:0]  r_rdata;

    // memory port
    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata;

    logic [16:0] r_clr;
    logic [1:0]  r_act;
    logic [15:0] r_haddr;
    logic [7:0]  r_hdata;
    logic [7:0]  r_opc, r_arg;
    logic [7:0]  r_a, r_b, r_res;
    logic [1:0]  r_flt;
    logic        r_wr;
    t_reg_idx    r_wdst;
    logic        r_ovalid;
    logic [2:0]  r_dcnt;
    logic [7:0]  r_quo;
    logic [8:0]  r_rem;

    logic        take;
    logic        p1_wrap;
    t_reg_idx    ra1, ra2;
    logic [8:0]  trial;

    // decode results, registered in the decode state
    logic        d_wr;
    t_reg_idx    d_wdst;
    logic [1:0]  d_flt;
    logic [7:0]  d_res;
    logic [7:0]  d_a, d_b;

    assign take    = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign ra1     = r_arg[7:4];
    assign ra2     = r_arg[3:0];
    assign p1_wrap = (r_rf[REG_P1] == 8'd254);
    // restoring divider step
    assign trial   = {r_rem[7:0], r_a[3'd7 - r_dcnt]} - {1'b0, r_b};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:     if (r_clr[16]) n_state = ST_IDLE;
            ST_IDLE: begin
                if (take) begin
                    if (t_action'(i_action) == ACT_STEP) n_state = ST_FETCH_OP;
                    else n_state = ST_HOST;
                end
            end
            ST_HOST:      n_state = ST_DONE;
            ST_FETCH_OP:  n_state = ST_FETCH_ARG;
            ST_FETCH_ARG: n_state = ST_ARG;
            ST_ARG:       n_state = ST_DECODE;
            ST_DECODE: begin
                if (d_flt != FLT_NONE) n_state = ST_DONE;
                else if (r_opc == OP_DIV || r_opc == OP_MOD) n_state = ST_DIV;
                else if (r_opc == OP_LD || r_opc == OP_ST) n_state = ST_MEM;
                else n_state = ST_WRITE;
            end
            ST_DIV:       if (r_dcnt == 3'd7) n_state = ST_WRITE;
            ST_MEM:       n_state = ST_WRITE;
            ST_WRITE:     n_state = ST_DONE;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_haddr;
        mem_wdata = r_hdata;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = !r_clr[16];
                mem_addr  = r_clr[15:0];
                mem_wdata = 8'd0;
            end
            ST_HOST:      mem_we = (t_action'(r_act) == ACT_WRITE);
            ST_FETCH_OP:  mem_addr = {r_rf[REG_P0], r_rf[REG_P1]};
            ST_FETCH_ARG: mem_addr = {r_rf[REG_P0], r_rf[REG_P1] + 8'd1};
            ST_MEM: begin
                mem_addr  = {r_rf[REG_S], r_arg};
                mem_we    = (r_opc == OP_ST);
                mem_wdata = r_rf[REG_T];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rdata <= r_mem[mem_addr];
    end

    // instruction decode and combinational operations
    always_comb begin
        d_wr   = 1'b1;
        d_wdst = ra1;
        d_flt  = FLT_NONE;
        d_res  = 8'd0;
        d_a    = 8'd0;
        d_b    = 8'd0;
        if (r_opc > OP_ST) begin
            d_flt = FLT_OPCODE;
            d_wr  = 1'b0;
        end else if (r_opc == OP_LDT || r_opc == OP_LD) begin
            d_wdst = REG_T;
            d_res  = r_arg;
        end else if (r_opc == OP_JMP) begin
            d_wr = (r_rf[REG_T] != 8'd0);
        end else if (r_opc == OP_ST) begin
            d_wr = 1'b0;
        end else if (ra1 >= t_reg_idx'(RegCount) || ra2 >= t_reg_idx'(RegCount)) begin
            d_flt = FLT_REG;
            d_wr  = 1'b0;
        end else begin
            d_a = r_rf[ra1];
            d_b = r_rf[ra2];
            if ((r_opc == OP_DIV || r_opc == OP_MOD) && d_b == 8'd0) begin
                d_flt = FLT_DIV0;
                d_wr  = 1'b0;
            end
            if (r_opc == OP_EQ || r_opc == OP_GT) d_wdst = REG_T;
            unique case (r_opc)
                OP_MOV:  d_res = d_b;
                OP_ADD:  d_res = d_a + d_b;
                OP_SUB:  d_res = d_a - d_b;
                OP_MUL:  d_res = 8'(d_a * d_b);
                OP_AND:  d_res = d_a & d_b;
                OP_OR:   d_res = d_a | d_b;
                OP_XOR:  d_res = d_a ^ d_b;
                OP_NOT:  d_res = ~d_b;
                OP_SHL:  d_res = (d_b >= 8'd8) ? 8'd0 : d_a << d_b[2:0];
                OP_SHR:  d_res = (d_b >= 8'd8) ? 8'd0 : d_a >> d_b[2:0];
                OP_EQ:   d_res = {7'd0, d_a == d_b};
                OP_GT:   d_res = {7'd0, d_a > d_b};
                default: d_res = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            // P0 and S start at five, the rest at zero
            for (int i = 0; i < RegCount; i++)
                r_rf[i] <= (i == int'(REG_P0) || i == int'(REG_S)) ? 8'd5 : 8'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 17'd1;
            if (r_state == ST_DONE) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            // pc advances once the argument fetch is issued
            if (r_state == ST_FETCH_ARG) begin
                if (p1_wrap) r_rf[REG_P0] <= r_rf[REG_P0] + 8'd1;
                r_rf[REG_P1] <= r_rf[REG_P1] + 8'd2;
            end
            if (r_state == ST_WRITE && r_wr) begin
                if (r_opc == OP_JMP) begin
                    r_rf[REG_P0] <= r_rf[REG_S];
                    r_rf[REG_P1] <= r_arg;
                end else begin
                    r_rf[r_wdst] <= (r_opc == OP_LD) ? r_rdata : r_res;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_act   <= i_action;
                r_haddr <= i_host_address;
                r_hdata <= i_host_data;
            end
            ST_FETCH_ARG: r_opc <= r_rdata;
            // argument arrives in the cycle after its fetch
            ST_ARG:       r_arg <= r_rdata;
            ST_DECODE: begin
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= '0;
                r_wr   <= d_wr;
                r_wdst <= d_wdst;
                r_flt  <= d_flt;
                r_a    <= d_a;
                r_b    <= d_b;
                r_res  <= d_res;
            end
            ST_DIV: begin
                r_dcnt <= r_dcnt + 3'd1;
                if (!trial[8]) begin
                    r_rem <= trial;
                    r_quo <= {r_quo[6:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[7:0], r_a[3'd7 - r_dcnt]};
                    r_quo <= {r_quo[6:0], 1'b0};
                end
                if (r_dcnt == 3'd7) begin
                    r_res <= (r_opc == OP_DIV)
                        ? {r_quo[6:0], !trial[8]}
                        : (trial[8] ? {r_rem[6:0], r_a[0]} : trial[7:0]);
                end
            end
            ST_DONE: begin
                if (t_action'(r_act) == ACT_STEP) begin
                    o_read_data         <= 8'd0;
                    o_executed_opcode   <= r_opc;
                    o_executed_argument <= r_arg;
                    o_fault             <= r_flt;
                end else begin
                    // host read data came back from the access cycle
                    o_read_data         <= (t_action'(r_act) == ACT_READ) ? r_rdata : 8'd0;
                    o_executed_opcode   <= 8'd0;
                    o_executed_argument <= 8'd0;
                    o_fault             <= FLT_NONE;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("accepted while busy");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> !r_ovalid)
        else $error("result overwritten");
    a_host_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && o_read_data != 8'd0) |-> o_fault == FLT_NONE)
        else $error("fault on host read");
`endif

endmodule
